FILE: rtl/bcsc_pkg.sv
package bcsc_pkg;

    localparam int COORD_W          = 24;
    localparam int WINDOW_FRAMES    = 15;
    localparam int MAX_FRAME_POINTS = 65536;

    localparam int FSUM_W    = 41;
    localparam int FCNT_W    = $clog2(MAX_FRAME_POINTS + 1);
    localparam int WSUM_W    = 45;
    localparam int WCNT_W    = 21;
    localparam int HEAD_W    = $clog2(WINDOW_FRAMES);
    localparam int HELD_W    = $clog2(WINDOW_FRAMES + 1);
    localparam int DIV_CNT_W = $clog2(WSUM_W + 1);

    localparam int MQ_DEPTH  = 4;
    localparam int MQ_AW     = $clog2(MQ_DEPTH);

    localparam int CFG_IDX_W = 3;

    typedef enum logic {
        OP_POINT = 1'b0,
        OP_EOF   = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE = 3'd0,
        REG_X_MIN  = 3'd1,
        REG_X_MAX  = 3'd2,
        REG_Y_MIN  = 3'd3,
        REG_Y_MAX  = 3'd4,
        REG_Z_MIN  = 3'd5,
        REG_Z_MAX  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        t_op                        op;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
        logic signed [COORD_W-1:0]  point_z;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_W-1:0]  centroid_x;
        logic signed [COORD_W-1:0]  centroid_y;
        logic signed [COORD_W-1:0]  centroid_z;
        logic                       empty_window;
        logic                       count_overflow;
    } t_out_word;

endpackage

FILE: rtl/bcsc_front.sv
module bcsc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  bcsc_pkg::t_in_word                  i_data,
    input  logic                                i_cfg_we,
    input  logic [bcsc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bcsc_pkg::COORD_W-1:0]        i_cfg_wdata,
    output logic                                o_mq_push,
    output bcsc_pkg::t_in_word                  o_mq_word,
    input  logic                                i_mq_full
);
    import bcsc_pkg::*;

    logic                       r_enable;
    logic signed [COORD_W-1:0]  r_x_min, r_x_max, r_y_min, r_y_max, r_z_min, r_z_max;
    logic                       r_valid;
    t_in_word                   r_word;

    logic in_box;
    logic keep;
    logic advance;
    logic accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_x_min  <= '0;
            r_x_max  <= '0;
            r_y_min  <= '0;
            r_y_max  <= '0;
            r_z_min  <= '0;
            r_z_max  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ENABLE: r_enable <= i_cfg_wdata[0];
                REG_X_MIN:  r_x_min  <= i_cfg_wdata;
                REG_X_MAX:  r_x_max  <= i_cfg_wdata;
                REG_Y_MIN:  r_y_min  <= i_cfg_wdata;
                REG_Y_MAX:  r_y_max  <= i_cfg_wdata;
                REG_Z_MIN:  r_z_min  <= i_cfg_wdata;
                REG_Z_MAX:  r_z_max  <= i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    // inclusive bounds; an inverted box keeps nothing
    assign in_box = (i_data.point_x >= r_x_min) && (i_data.point_x <= r_x_max)
                 && (i_data.point_y >= r_y_min) && (i_data.point_y <= r_y_max)
                 && (i_data.point_z >= r_z_min) && (i_data.point_z <= r_z_max);

    assign keep    = r_enable && ((i_data.op == OP_EOF) || in_box);
    assign advance = !r_valid || !i_mq_full;
    assign accept  = push && advance;
    assign full    = !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept && keep) begin
            r_valid <= 1'b1;
        end else if (advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_word <= i_data;
        end
    end

    assign o_mq_push = r_valid;
    assign o_mq_word = r_word;

endmodule

FILE: rtl/bcsc_queue.sv
module bcsc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  bcsc_pkg::t_in_word  i_word,
    input  logic                i_pop,
    output logic                o_empty,
    output bcsc_pkg::t_in_word  o_word
);
    import bcsc_pkg::*;

    t_in_word           r_mem [MQ_DEPTH];
    logic [MQ_AW-1:0]   r_wr;
    logic [MQ_AW-1:0]   r_rd;
    logic [MQ_AW:0]     r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (MQ_AW + 1)'(MQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == MQ_AW'(MQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == MQ_AW'(MQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    assign o_word = r_mem[r_rd];

endmodule

FILE: rtl/bcsc_div.sv
module bcsc_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [bcsc_pkg::WSUM_W-1:0]  i_sum,
    input  logic [bcsc_pkg::WCNT_W-1:0]         i_count,
    output logic                                o_busy,
    output logic signed [bcsc_pkg::COORD_W-1:0] o_quot
);
    import bcsc_pkg::*;

    logic [DIV_CNT_W-1:0]   r_cnt;
    logic                   r_neg;
    logic [WCNT_W-1:0]      r_rem;
    logic [WCNT_W-1:0]      r_den;
    logic [WSUM_W-1:0]      r_q;

    logic [WSUM_W-1:0]      mag;
    logic [WCNT_W:0]        rem_sh;
    logic [WCNT_W:0]        diff;
    logic                   ge;
    logic [COORD_W-1:0]     quot_mag;

    assign mag    = i_sum[WSUM_W-1] ? WSUM_W'(-i_sum) : WSUM_W'(i_sum);
    assign rem_sh = {r_rem, r_q[WSUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_den});
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(WSUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // restoring divide on magnitudes, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_sum[WSUM_W-1];
            r_q   <= mag;
            r_rem <= '0;
            r_den <= i_count;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[WCNT_W-1:0] : rem_sh[WCNT_W-1:0];
            r_q   <= {r_q[WSUM_W-2:0], ge};
        end
    end

    assign o_busy   = (r_cnt != '0);
    assign quot_mag = r_q[COORD_W-1:0];
    assign o_quot   = r_neg ? -quot_mag : quot_mag;

endmodule

FILE: rtl/bcsc_back.sv
module bcsc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_mq_empty,
    input  bcsc_pkg::t_in_word  i_mq_word,
    output logic                o_mq_pop,
    output logic                empty,
    input  logic                pop,
    output bcsc_pkg::t_out_word o_data
);
    import bcsc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SUB  = 6'b000010,
        S_ADD  = 6'b000100,
        S_LOAD = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state                     r_state, n_state;

    logic signed [FSUM_W-1:0]   r_fsum_x, r_fsum_y, r_fsum_z;
    logic [FCNT_W-1:0]          r_fcnt;
    logic                       r_fovf;

    logic signed [FSUM_W-1:0]   r_ring_x [WINDOW_FRAMES];
    logic signed [FSUM_W-1:0]   r_ring_y [WINDOW_FRAMES];
    logic signed [FSUM_W-1:0]   r_ring_z [WINDOW_FRAMES];
    logic [FCNT_W-1:0]          r_ring_cnt [WINDOW_FRAMES];
    logic [WINDOW_FRAMES-1:0]   r_ring_ovf;

    logic signed [WSUM_W-1:0]   r_wsum_x, r_wsum_y, r_wsum_z;
    logic [WCNT_W-1:0]          r_wcnt;
    logic [HEAD_W-1:0]          r_head, n_head;
    logic [HELD_W-1:0]          r_held, n_held;

    logic                       r_out_valid;
    t_out_word                  r_out;

    logic                       window_full;
    logic                       frame_sat;
    logic                       out_load;
    logic                       div_start;
    logic [2:0]                 div_busy;
    logic signed [COORD_W-1:0]  quot_x, quot_y, quot_z;
    logic                       win_empty;

    assign window_full = (r_held == HELD_W'(WINDOW_FRAMES));
    assign frame_sat   = (r_fcnt == FCNT_W'(MAX_FRAME_POINTS));
    assign o_mq_pop    = (r_state == S_IDLE) && !i_mq_empty;
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || pop);
    assign div_start   = (r_state == S_LOAD);
    assign win_empty   = (r_wcnt == '0);

    assign n_head = (r_head == HEAD_W'(WINDOW_FRAMES - 1)) ? '0 : r_head + 1'b1;
    assign n_held = window_full ? r_held : r_held + 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_mq_pop && (i_mq_word.op == OP_EOF)) begin
                    n_state = S_SUB;
                end
            end
            S_SUB:  n_state = S_ADD;
            S_ADD:  n_state = (n_held == HELD_W'(WINDOW_FRAMES)) ? S_LOAD : S_IDLE;
            S_LOAD: n_state = S_DIV;
            S_DIV:  n_state = (div_busy == '0) ? S_OUT : S_DIV;
            S_OUT:  n_state = out_load ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fsum_x <= '0;
            r_fsum_y <= '0;
            r_fsum_z <= '0;
            r_fcnt   <= '0;
            r_fovf   <= 1'b0;
            r_wsum_x <= '0;
            r_wsum_y <= '0;
            r_wsum_z <= '0;
            r_wcnt   <= '0;
            r_head   <= '0;
            r_held   <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_IDLE) && o_mq_pop && (i_mq_word.op == OP_POINT)) begin
                // drop the point once the frame count is saturated
                if (frame_sat) begin
                    r_fovf <= 1'b1;
                end else begin
                    r_fsum_x <= r_fsum_x + FSUM_W'(i_mq_word.point_x);
                    r_fsum_y <= r_fsum_y + FSUM_W'(i_mq_word.point_y);
                    r_fsum_z <= r_fsum_z + FSUM_W'(i_mq_word.point_z);
                    r_fcnt   <= r_fcnt + 1'b1;
                end
            end
            if ((r_state == S_SUB) && window_full) begin
                r_wsum_x <= r_wsum_x - WSUM_W'(r_ring_x[r_head]);
                r_wsum_y <= r_wsum_y - WSUM_W'(r_ring_y[r_head]);
                r_wsum_z <= r_wsum_z - WSUM_W'(r_ring_z[r_head]);
                r_wcnt   <= r_wcnt - WCNT_W'(r_ring_cnt[r_head]);
            end
            if (r_state == S_ADD) begin
                r_wsum_x <= r_wsum_x + WSUM_W'(r_fsum_x);
                r_wsum_y <= r_wsum_y + WSUM_W'(r_fsum_y);
                r_wsum_z <= r_wsum_z + WSUM_W'(r_fsum_z);
                r_wcnt   <= r_wcnt + WCNT_W'(r_fcnt);
                r_head   <= n_head;
                r_held   <= n_held;
                r_fsum_x <= '0;
                r_fsum_y <= '0;
                r_fsum_z <= '0;
                r_fcnt   <= '0;
                r_fovf   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ADD) begin
            r_ring_x[r_head]   <= r_fsum_x;
            r_ring_y[r_head]   <= r_fsum_y;
            r_ring_z[r_head]   <= r_fsum_z;
            r_ring_cnt[r_head] <= r_fcnt;
            r_ring_ovf[r_head] <= r_fovf;
        end
    end

    bcsc_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (r_wsum_x),
        .i_count (r_wcnt),
        .o_busy  (div_busy[0]),
        .o_quot  (quot_x)
    );

    bcsc_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (r_wsum_y),
        .i_count (r_wcnt),
        .o_busy  (div_busy[1]),
        .o_quot  (quot_y)
    );

    bcsc_div u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (r_wsum_z),
        .i_count (r_wcnt),
        .o_busy  (div_busy[2]),
        .o_quot  (quot_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.centroid_x     <= win_empty ? '0 : quot_x;
            r_out.centroid_y     <= win_empty ? '0 : quot_y;
            r_out.centroid_z     <= win_empty ? '0 : quot_z;
            r_out.empty_window   <= win_empty;
            r_out.count_overflow <= |r_ring_ovf;
        end
    end

    assign empty  = !r_out_valid;
    assign o_data = r_out;

    a_fcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_fcnt <= FCNT_W'(MAX_FRAME_POINTS)))
        else $error("frame count above saturation limit");

    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (div_busy == 3'b111))
        else $error("dividers did not start together");

    a_window_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ADD) && (r_held == HELD_W'(WINDOW_FRAMES - 1)))
        |=> ((r_state == S_LOAD) && window_full))
        else $error("window filled without a divide");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result word loaded outside output state");

endmodule

FILE: rtl/box_crop_sliding_centroid.sv
// Crop-box filter with a sliding-window centroid. Each input word is either a
// point (op = point) or an end-of-frame marker. While enable is set, points
// inside the inclusive box are summed into the current frame; at each end of
// frame the frame goes into a ring of the last 15 frames and, once the ring is
// full, one result word carries the window centroid (sum / count, truncated
// toward zero), the empty-window flag and the overflow flag. While enable is
// clear every word is taken and dropped. The input side takes one word per
// cycle while full is low, into a registered classify stage and a 4-word queue.
// The back end takes a point in its idle state; an end of frame runs through
// the subtract and add states and, once the window is full, the load, divide
// (three 45-step restoring dividers side by side) and output states. A result
// waits in an output register, blocking the back end only when the next is due.
module box_crop_sliding_centroid (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  bcsc_pkg::t_in_word              i_data,
    output logic                            empty,
    input  logic                            pop,
    output bcsc_pkg::t_out_word             o_data,
    input  logic                            i_cfg_we,
    input  logic [bcsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bcsc_pkg::COORD_W-1:0]    i_cfg_wdata
);
    import bcsc_pkg::*;

    logic       mq_push;
    logic       mq_full;
    t_in_word   mq_in;
    logic       mq_pop;
    logic       mq_empty;
    t_in_word   mq_out;

    bcsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_mq_push   (mq_push),
        .o_mq_word   (mq_in),
        .i_mq_full   (mq_full)
    );

    bcsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mq_push),
        .o_full  (mq_full),
        .i_word  (mq_in),
        .i_pop   (mq_pop),
        .o_empty (mq_empty),
        .o_word  (mq_out)
    );

    bcsc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mq_empty (mq_empty),
        .i_mq_word  (mq_out),
        .o_mq_pop   (mq_pop),
        .empty      (empty),
        .pop        (pop),
        .o_data     (o_data)
    );

endmodule
